[rtl/dla_pkg.sv]
package dla_pkg;

  localparam int DLA_ACT_W    = 3;
  localparam int DLA_MASK_W   = 8;
  localparam int DLA_CNT_W    = 4;
  localparam int DLA_LEASE_W  = 16;
  localparam int DLA_DEV_W    = 3;
  localparam int DLA_ERR_W    = 3;
  localparam int DLA_FOUND_W  = 4;
  localparam int DLA_IN_W     = 40;
  localparam int DLA_OUT_W    = 40;

  localparam logic [2:0] DLA_REG_INVENTORY = 3'd0;

  typedef enum logic [DLA_ACT_W-1:0] {
    ACT_CHECK   = 3'd0,
    ACT_PICK    = 3'd1,
    ACT_ASSIGN  = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_QUERY   = 3'd4
  } dla_action_e;

  typedef enum logic [DLA_ERR_W-1:0] {
    ERR_NONE       = 3'd0,
    ERR_EMPTY_MASK = 3'd1,
    ERR_COUNT_ZERO = 3'd2,
    ERR_NO_INV     = 3'd3,
    ERR_HELD       = 3'd4,
    ERR_TOO_FEW    = 3'd5
  } dla_err_e;

  typedef struct packed {
    logic [DLA_ACT_W-1:0]   action;
    logic [DLA_MASK_W-1:0]  id_mask;
    logic [DLA_CNT_W-1:0]   count;
    logic [DLA_LEASE_W-1:0] lease;
    logic [DLA_DEV_W-1:0]   device_index;
  } dla_req_t;

  typedef struct packed {
    logic                   ok;
    logic                   waitable;
    logic [DLA_ERR_W-1:0]   error_code;
    logic [DLA_MASK_W-1:0]  result_mask;
    logic [DLA_LEASE_W-1:0] lease_out;
    logic [DLA_DEV_W-1:0]   held_device;
    logic [DLA_FOUND_W-1:0] free_found;
    logic                   is_held;
  } dla_res_t;

endpackage

[rtl/device_lease_allocator.sv]
// A request accepted on s_axis scans N = min(NUM_DEVICES, 8) holder tag RAM entries, one read
//   per cycle, with each write-back in the cycle after its read; the last and fin states follow,
//   and the result is registered onto m_axis. A new request is accepted only in idle, after fin.
// A result held in the output register and not yet drained keeps the engine in fin, so the next request waits.
// Reset (rst_ni low, asynchronous): all devices free, lease counter and inventory zero;
//   per-entry valid flops stand in for the tag RAM contents, so there is no clearing pass.
module device_lease_allocator #(
  parameter int NUM_DEVICES = 8,
  parameter int LEASE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // action[2:0], id_mask[10:3], count[14:11], lease[30:15], device_index[33:31], zero fill
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ok[0], waitable[1], error_code[4:2], result_mask[12:5], lease_out[28:13],
  // held_device[31:29], free_found[35:32], is_held[36], zero fill
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import dla_pkg::*;

  logic [DLA_MASK_W-1:0] inventory_q;
  dla_req_t              req;
  dla_res_t              res;
  logic                  res_valid, res_ready;
  logic                  m_valid_q;
  logic [DLA_OUT_W-1:0]  m_data_q;

  assign pready = 1'b1;
  assign prdata = (paddr == DLA_REG_INVENTORY) ? 32'(inventory_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inventory_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == DLA_REG_INVENTORY) begin
      inventory_q <= pwdata[DLA_MASK_W-1:0];
    end
  end

  assign req.action       = s_axis_tdata[2:0];
  assign req.id_mask      = s_axis_tdata[10:3];
  assign req.count        = s_axis_tdata[14:11];
  assign req.lease        = s_axis_tdata[30:15];
  assign req.device_index = s_axis_tdata[33:31];

  dla_engine #(
    .NUM_DEVICES(NUM_DEVICES),
    .LEASE_WIDTH(LEASE_WIDTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .inventory_i(inventory_q),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output slot frees when empty or drained this cycle
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
      m_data_q  <= {3'b000, res.is_held, res.free_found, res.held_device,
                    res.lease_out, res.result_mask, res.error_code,
                    res.waitable, res.ok};
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[rtl/dla_ram.sv]
module dla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/dla_engine.sv]
module dla_engine #(
  parameter int NUM_DEVICES = 8,
  parameter int LEASE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dla_pkg::DLA_MASK_W-1:0] inventory_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  dla_pkg::dla_req_t             req_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output dla_pkg::dla_res_t             res_o
);

  import dla_pkg::*;

  localparam int SCAN_N = (NUM_DEVICES < DLA_MASK_W) ? NUM_DEVICES : DLA_MASK_W;
  localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(SCAN_N - 1);
  localparam logic [DLA_MASK_W-1:0] RANGE_MASK = DLA_MASK_W'((1 << SCAN_N) - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FIN
  } state_e;

  state_e                 state_q, state_d;
  dla_req_t               req_q, req_d;
  logic [LEASE_WIDTH-1:0] lease_ctr_q, lease_ctr_d, lease_nxt;
  logic [AW-1:0]          cnt_q, cnt_d;
  logic                   pvld_q, pvld_d;
  logic [AW-1:0]          pidx_q, pidx_d;
  logic [NUM_DEVICES-1:0] tag_vld_q, tag_vld_d;
  logic                   any_q, any_d;
  logic                   conflict_q, conflict_d;
  logic [DLA_DEV_W-1:0]   hdev_q, hdev_d;
  logic [DLA_LEASE_W-1:0] lout_q, lout_d;
  logic [DLA_MASK_W-1:0]  rmask_q, rmask_d;
  logic [DLA_FOUND_W-1:0] found_q, found_d;
  logic                   held_q, held_d;

  logic                   ram_we, ram_re;
  logic [LEASE_WIDTH-1:0] ram_wdata, ram_rdata, tag;
  logic [DLA_MASK_W-1:0]  sel;
  logic                   id_hit, inv_hit, tag_zero, accept;
  logic                   query_in_range;

  dla_ram #(
    .WIDTH(LEASE_WIDTH),
    .DEPTH(NUM_DEVICES)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pidx_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign ram_re      = (state_q == ST_SCAN);

  // never-written entries read as free
  assign tag      = tag_vld_q[pidx_q] ? ram_rdata : '0;
  assign tag_zero = (tag == '0);
  assign sel      = DLA_MASK_W'(1) << pidx_q;
  assign id_hit   = |(req_q.id_mask & sel);
  assign inv_hit  = |(inventory_i & sel);
  assign query_in_range = (32'(req_q.device_index) < SCAN_N);

  always_comb begin
    lease_nxt = lease_ctr_q + LEASE_WIDTH'(1);
    if (lease_nxt == '0) begin
      lease_nxt = LEASE_WIDTH'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    lease_ctr_d = lease_ctr_q;
    cnt_d       = cnt_q;
    pvld_d      = 1'b0;
    pidx_d      = cnt_q;
    tag_vld_d   = tag_vld_q;
    any_d       = any_q;
    conflict_d  = conflict_q;
    hdev_d      = hdev_q;
    lout_d      = lout_q;
    rmask_d     = rmask_q;
    found_d     = found_q;
    held_d      = held_q;
    ram_we      = 1'b0;
    ram_wdata   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d      = req_i;
          cnt_d      = '0;
          any_d      = 1'b0;
          conflict_d = 1'b0;
          hdev_d     = '0;
          lout_d     = '0;
          rmask_d    = '0;
          found_d    = '0;
          held_d     = 1'b0;
          if (req_i.action == ACT_ASSIGN) begin
            lease_ctr_d = lease_nxt;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pvld_d = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_LAST: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // read-modify-write of the entry read in the previous cycle
    if (pvld_q) begin
      case (req_q.action)
        ACT_CHECK: begin
          if (id_hit && !conflict_q) begin
            any_d = 1'b1;
            if (!tag_zero) begin
              conflict_d = 1'b1;
              hdev_d     = DLA_DEV_W'(pidx_q);
              lout_d     = DLA_LEASE_W'(tag);
            end else begin
              rmask_d = rmask_q | sel;
            end
          end
        end
        ACT_PICK: begin
          if (inv_hit && tag_zero && (found_q < req_q.count)) begin
            rmask_d = rmask_q | sel;
            found_d = found_q + DLA_FOUND_W'(1);
          end
        end
        ACT_ASSIGN: begin
          if (id_hit) begin
            ram_we            = 1'b1;
            ram_wdata         = lease_ctr_q;
            tag_vld_d[pidx_q] = 1'b1;
            rmask_d           = rmask_q | sel;
          end
        end
        ACT_RELEASE: begin
          if ((req_q.lease != '0) && (32'(tag) == 32'(req_q.lease))) begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            rmask_d   = rmask_q | sel;
          end
        end
        ACT_QUERY: begin
          if (32'(pidx_q) == 32'(req_q.device_index)) begin
            lout_d = DLA_LEASE_W'(tag);
            held_d = !tag_zero;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o       = '0;
    res_valid_o = (state_q == ST_FIN);
    case (req_q.action)
      ACT_CHECK: begin
        if (!any_q) begin
          res_o.error_code = ERR_EMPTY_MASK;
        end else if (conflict_q) begin
          res_o.waitable    = 1'b1;
          res_o.error_code  = ERR_HELD;
          res_o.held_device = hdev_q;
          res_o.lease_out   = lout_q;
        end else begin
          res_o.ok          = 1'b1;
          res_o.result_mask = rmask_q;
        end
      end
      ACT_PICK: begin
        if (req_q.count == '0) begin
          res_o.error_code = ERR_COUNT_ZERO;
        end else if ((inventory_i & RANGE_MASK) == '0) begin
          res_o.error_code = ERR_NO_INV;
        end else if (found_q == req_q.count) begin
          res_o.ok          = 1'b1;
          res_o.result_mask = rmask_q;
          res_o.free_found  = found_q;
        end else begin
          res_o.waitable   = 1'b1;
          res_o.error_code = ERR_TOO_FEW;
          res_o.free_found = found_q;
        end
      end
      ACT_ASSIGN: begin
        res_o.ok          = 1'b1;
        res_o.result_mask = rmask_q;
        res_o.lease_out   = DLA_LEASE_W'(lease_ctr_q);
      end
      ACT_RELEASE: begin
        res_o.ok          = 1'b1;
        res_o.result_mask = rmask_q;
      end
      ACT_QUERY: begin
        if (query_in_range) begin
          res_o.ok        = 1'b1;
          res_o.lease_out = lout_q;
          res_o.is_held   = held_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      lease_ctr_q <= '0;
      cnt_q       <= '0;
      pvld_q      <= 1'b0;
      pidx_q      <= '0;
      tag_vld_q   <= '0;
      any_q       <= 1'b0;
      conflict_q  <= 1'b0;
      hdev_q      <= '0;
      lout_q      <= '0;
      rmask_q     <= '0;
      found_q     <= '0;
      held_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      lease_ctr_q <= lease_ctr_d;
      cnt_q       <= cnt_d;
      pvld_q      <= pvld_d;
      pidx_q      <= pidx_d;
      tag_vld_q   <= tag_vld_d;
      any_q       <= any_d;
      conflict_q  <= conflict_d;
      hdev_q      <= hdev_d;
      lout_q      <= lout_d;
      rmask_q     <= rmask_d;
      found_q     <= found_d;
      held_q      <= held_d;
    end
  end

  a_write_in_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> pvld_q)
    else $error("tag write without a pending read");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pvld_q)
    else $error("scan pipe busy while idle");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (32'(found_q) <= SCAN_N))
    else $error("free count beyond scanned devices");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q == LAST_IDX) |=> (state_q == ST_LAST && pvld_q))
    else $error("scan did not close on its last entry");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import dla_pkg::*;

  localparam int NUM_DEV = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 160;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: holder tag per device, lease counter, inventory register
  logic [DLA_LEASE_W-1:0] tag_q [NUM_DEV];
  logic [DLA_LEASE_W-1:0] lease_ctr = '0;
  logic [DLA_MASK_W-1:0]  inv_mask = '0;

  dla_req_t pending_reqs [$];
  dla_res_t lease_results_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  device_lease_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int d = 0; d < NUM_DEV; d++) tag_q[d] = '0;
  end

  function automatic dla_req_t mk_req(logic [DLA_ACT_W-1:0] act, logic [DLA_MASK_W-1:0] ids,
                                      logic [DLA_CNT_W-1:0] cnt, logic [DLA_LEASE_W-1:0] ls,
                                      logic [DLA_DEV_W-1:0] dev);
    dla_req_t rq;
    rq.action = act;
    rq.id_mask = ids;
    rq.count = cnt;
    rq.lease = ls;
    rq.device_index = dev;
    return rq;
  endfunction

  function automatic void add_req(dla_req_t rq);
    pending_reqs.insert(pending_reqs.size(), rq);
  endfunction

  // compute the outcome of one request and update the tag table
  function automatic dla_res_t lease_table_apply(dla_req_t rq);
    dla_res_t r;
    bit conflict;
    logic [DLA_FOUND_W-1:0] found;
    r = '0;
    conflict = 1'b0;
    found = '0;
    case (rq.action)
      ACT_CHECK: begin
        for (int d = 0; d < NUM_DEV; d++) begin
          if (rq.id_mask[d] && tag_q[d] != 0 && !conflict) begin
            conflict = 1'b1;
            r.held_device = DLA_DEV_W'(d);
            r.lease_out = tag_q[d];
          end
        end
        if (rq.id_mask == 0) begin
          r.error_code = ERR_EMPTY_MASK;
        end else if (conflict) begin
          r.waitable = 1'b1;
          r.error_code = ERR_HELD;
        end else begin
          r.ok = 1'b1;
          r.result_mask = rq.id_mask;
        end
      end
      ACT_PICK: begin
        if (rq.count == 0) begin
          r.error_code = ERR_COUNT_ZERO;
        end else if (inv_mask == 0) begin
          r.error_code = ERR_NO_INV;
        end else begin
          for (int d = 0; d < NUM_DEV; d++) begin
            if (found < rq.count && inv_mask[d] && tag_q[d] == 0) begin
              r.result_mask[d] = 1'b1;
              found++;
            end
          end
          r.free_found = found;
          if (found == rq.count) begin
            r.ok = 1'b1;
          end else begin
            r.waitable = 1'b1;
            r.error_code = ERR_TOO_FEW;
            r.result_mask = '0;
          end
        end
      end
      ACT_ASSIGN: begin
        lease_ctr = lease_ctr + DLA_LEASE_W'(1);
        if (lease_ctr == 0) lease_ctr = DLA_LEASE_W'(1);
        for (int d = 0; d < NUM_DEV; d++)
          if (rq.id_mask[d]) tag_q[d] = lease_ctr;
        r.ok = 1'b1;
        r.result_mask = rq.id_mask;
        r.lease_out = lease_ctr;
      end
      ACT_RELEASE: begin
        r.ok = 1'b1;
        if (rq.lease != 0) begin
          for (int d = 0; d < NUM_DEV; d++) begin
            if (tag_q[d] == rq.lease) begin
              tag_q[d] = '0;
              r.result_mask[d] = 1'b1;
            end
          end
        end
      end
      ACT_QUERY: begin
        r.ok = 1'b1;
        r.lease_out = tag_q[rq.device_index];
        r.is_held = (tag_q[rq.device_index] != 0);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dla_req_t rand_request();
    dla_req_t rq;
    int unsigned sel;
    rq = mk_req(ACT_CHECK, DLA_MASK_W'($urandom_range(255)), DLA_CNT_W'($urandom_range(15)),
                DLA_LEASE_W'($urandom_range(65535)), DLA_DEV_W'($urandom_range(7)));
    sel = $urandom_range(99);
    if (sel < 20) begin
      rq.action = ACT_CHECK;
    end else if (sel < 40) begin
      rq.action = ACT_PICK;
      if ($urandom_range(3) != 0) rq.count = DLA_CNT_W'($urandom_range(4, 1));
    end else if (sel < 60) begin
      rq.action = ACT_ASSIGN;
      if ($urandom_range(3) == 0) rq.id_mask = 8'b1 << $urandom_range(7);
    end else if (sel < 80) begin
      rq.action = ACT_RELEASE;
      // mostly release a lease taken from the tag table (zero if that device is free)
      if ($urandom_range(3) != 0) rq.lease = tag_q[$urandom_range(NUM_DEV - 1)];
    end else if (sel < 94) begin
      rq.action = ACT_QUERY;
    end else begin
      rq.action = DLA_ACT_W'(ACT_QUERY + 1 + $urandom_range(2));
    end
    return rq;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        lease_results_q.insert(lease_results_q.size(),
            lease_table_apply(mk_req(s_axis_tdata[2:0],
            s_axis_tdata[10:3], s_axis_tdata[14:11], s_axis_tdata[30:15],
            s_axis_tdata[33:31])));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          dla_req_t rq;
          rq = pending_reqs.pop_front();
          s_axis_tdata <= {6'b0, rq.device_index, rq.lease, rq.count, rq.id_mask, rq.action};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lease_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_axis_tdata);
          error_count++;
        end else begin
          dla_res_t want;
          want = lease_results_q.pop_front();
          check_field("ok", 32'(want.ok), 32'(m_axis_tdata[0]));
          check_field("waitable", 32'(want.waitable), 32'(m_axis_tdata[1]));
          check_field("error_code", 32'(want.error_code), 32'(m_axis_tdata[4:2]));
          check_field("result_mask", 32'(want.result_mask), 32'(m_axis_tdata[12:5]));
          check_field("lease_out", 32'(want.lease_out), 32'(m_axis_tdata[28:13]));
          check_field("held_device", 32'(want.held_device), 32'(m_axis_tdata[31:29]));
          check_field("free_found", 32'(want.free_found), 32'(m_axis_tdata[35:32]));
          check_field("is_held", 32'(want.is_held), 32'(m_axis_tdata[36]));
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen <= hold_seq;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || lease_results_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_inventory(logic [DLA_MASK_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DLA_REG_INVENTORY;
    pwdata <= {24'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    inv_mask = value;
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {24'b0, value}) begin
      $display("%0t: inventory readback mismatch, expected 0x%0h, actual 0x%0h",
               $time, value, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_req(dla_req_t rq);
    while (pending_reqs.size() >= 2) @(posedge clk_i);
    add_req(rq);
  endtask

  task automatic run_random(int n, bit with_hold, bit with_pause);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_seq++;
      if (with_pause && i == n / 2) wait_idle();
      push_req(rand_request());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: no inventory yet
    write_inventory(8'h00);
    add_req(mk_req(ACT_CHECK, 8'h00, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_CHECK, 8'hFF, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_QUERY, 8'h00, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_PICK, 8'h00, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_PICK, 8'h00, 4'd15, 16'h0000, 3'd0));
    add_req(mk_req(ACT_ASSIGN, 8'h00, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_ASSIGN, 8'hF0, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_CHECK, 8'h18, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_QUERY, 8'h00, 4'd0, 16'h0000, 3'd7));
    add_req(mk_req(ACT_ASSIGN, 8'h3C, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_RELEASE, 8'h00, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_RELEASE, 8'h00, 4'd0, 16'h0001, 3'd0));
    add_req(mk_req(ACT_RELEASE, 8'h00, 4'd0, 16'h0002, 3'd0));
    for (int a = ACT_QUERY + 1; a < 8; a++)
      add_req(mk_req(DLA_ACT_W'(a), 8'hFF, 4'd15, 16'hFFFF, 3'd7));
    add_req(mk_req(ACT_QUERY, 8'h00, 4'd0, 16'h0000, 3'd4));
    wait_idle();

    // directed: full inventory
    write_inventory(8'hFF);
    add_req(mk_req(ACT_PICK, 8'h00, 4'd15, 16'h0000, 3'd0));
    add_req(mk_req(ACT_PICK, 8'h00, 4'd4, 16'h0000, 3'd0));
    add_req(mk_req(ACT_RELEASE, 8'h00, 4'd0, 16'h0003, 3'd0));
    add_req(mk_req(ACT_PICK, 8'h00, 4'd8, 16'h0000, 3'd0));
    add_req(mk_req(ACT_ASSIGN, 8'hFF, 4'd0, 16'h0000, 3'd0));
    add_req(mk_req(ACT_PICK, 8'h00, 4'd1, 16'h0000, 3'd0));
    add_req(mk_req(ACT_RELEASE, 8'h00, 4'd0, 16'hFFFF, 3'd0));
    add_req(mk_req(ACT_RELEASE, 8'h00, 4'd0, 16'h0004, 3'd0));
    wait_idle();

    // sender slow, receiver slower; long receiver hold partway through
    send_idle_pct = 11;
    recv_idle_pct = 52;
    write_inventory(8'h81);
    run_random(RANDOM_PER_PHASE, 1'b1, 1'b0);
    wait_idle();

    // receiver fast, sender slow; sender drains the pipe partway through
    send_idle_pct = 52;
    recv_idle_pct = 11;
    write_inventory(DLA_MASK_W'($urandom_range(255)));
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b1);
    wait_idle();

    // no idling: spread a few single-device leases, then random traffic
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_inventory(8'h7E);
    for (int i = 0; i < 4; i++)
      add_req(mk_req(ACT_ASSIGN, 8'b1 << (2 * i), 4'd0, 16'h0000, 3'd0));
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b0);
    wait_idle();

    if (lease_results_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, lease_results_q.size());
      error_count++;
    end
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
